// ----- src/nfau_pkg.sv -----
// Shared types and constants for the nimber field arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package nfau_pkg;
    localparam int FIELD_WIDTH_DEF = 64;

    typedef enum logic [2:0] {
        FUNC_ADD = 3'd0,
        FUNC_MUL = 3'd1,
        FUNC_DIV = 3'd2,
        FUNC_POW = 3'd3,
        FUNC_INV = 3'd4
    } t_func;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
    } t_in;

    typedef struct packed {
        logic [63:0] result;
        logic        zero_divide;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_WAIT,
        ST_SQ_WAIT,
        ST_FIN_WAIT,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

// ----- src/nfau_mul.sv -----
// Shared nim multiplier: one 32-bit nim product per cycle, four steps for a 64-bit field.
`timescale 1ns / 1ps
`default_nettype none
module nfau_mul
    import nfau_pkg::*;
#(
    parameter int FBITS = FIELD_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_x,
    input  wire logic [63:0] i_y,
    output logic             o_done,
    output logic [63:0]      o_p
);
    localparam logic [1:0] STEP_LO   = 2'd0;
    localparam logic [1:0] STEP_HI   = 2'd1;
    localparam logic [1:0] STEP_MID  = 2'd2;
    localparam logic [1:0] STEP_FOLD = 2'd3;
    localparam logic [1:0] LAST_STEP = (FBITS == 64) ? STEP_FOLD : STEP_LO;

    // Each level: high half is mid ^ lo, low half is lo ^ (hi times the top half-bit).
    function automatic logic [1:0] nim_mul2(input logic [1:0] x, input logic [1:0] y);
        logic lo;
        logic hi;
        logic mid;
        lo  = x[0] & y[0];
        hi  = x[1] & y[1];
        mid = (x[0] ^ x[1]) & (y[0] ^ y[1]);
        return {mid ^ lo, lo ^ hi};
    endfunction

    function automatic logic [3:0] nim_mul4(input logic [3:0] x, input logic [3:0] y);
        logic [1:0] lo;
        logic [1:0] hi;
        logic [1:0] mid;
        lo  = nim_mul2(x[1:0], y[1:0]);
        hi  = nim_mul2(x[3:2], y[3:2]);
        mid = nim_mul2(x[1:0] ^ x[3:2], y[1:0] ^ y[3:2]);
        return {mid ^ lo, lo ^ nim_mul2(hi, 2'h2)};
    endfunction

    function automatic logic [7:0] nim_mul8(input logic [7:0] x, input logic [7:0] y);
        logic [3:0] lo;
        logic [3:0] hi;
        logic [3:0] mid;
        lo  = nim_mul4(x[3:0], y[3:0]);
        hi  = nim_mul4(x[7:4], y[7:4]);
        mid = nim_mul4(x[3:0] ^ x[7:4], y[3:0] ^ y[7:4]);
        return {mid ^ lo, lo ^ nim_mul4(hi, 4'h8)};
    endfunction

    function automatic logic [15:0] nim_mul16(input logic [15:0] x, input logic [15:0] y);
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] mid;
        lo  = nim_mul8(x[7:0], y[7:0]);
        hi  = nim_mul8(x[15:8], y[15:8]);
        mid = nim_mul8(x[7:0] ^ x[15:8], y[7:0] ^ y[15:8]);
        return {mid ^ lo, lo ^ nim_mul8(hi, 8'h80)};
    endfunction

    function automatic logic [31:0] nim_mul32(input logic [31:0] x, input logic [31:0] y);
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] mid;
        lo  = nim_mul16(x[15:0], y[15:0]);
        hi  = nim_mul16(x[31:16], y[31:16]);
        mid = nim_mul16(x[15:0] ^ x[31:16], y[15:0] ^ y[31:16]);
        return {mid ^ lo, lo ^ nim_mul16(hi, 16'h8000)};
    endfunction

    logic          r_run;
    logic [1:0]    r_step;
    logic [63:0]   r_x;
    logic [63:0]   r_y;
    logic [31:0]   r_pl;
    logic [31:0]   r_ph;
    logic [31:0]   r_pm;
    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [31:0]   mul_p;

    // Low halves, high halves, half sums, then fold the high product back.
    always_comb begin
        case (r_step)
            STEP_LO: begin
                mul_a = r_x[31:0];
                mul_b = r_y[31:0];
            end
            STEP_HI: begin
                mul_a = r_x[63:32];
                mul_b = r_y[63:32];
            end
            STEP_MID: begin
                mul_a = r_x[31:0] ^ r_x[63:32];
                mul_b = r_y[31:0] ^ r_y[63:32];
            end
            default: begin
                mul_a = r_ph;
                mul_b = 32'h8000_0000;
            end
        endcase
        mul_p = nim_mul32(mul_a, mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_step <= STEP_LO;
            r_x    <= 64'd0;
            r_y    <= 64'd0;
            r_pl   <= 32'd0;
            r_ph   <= 32'd0;
            r_pm   <= 32'd0;
            o_done <= 1'b0;
            o_p    <= 64'd0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= STEP_LO;
                r_x    <= i_x;
                r_y    <= i_y;
            end else if (r_run) begin
                if (r_step == STEP_LO) r_pl <= mul_p;
                if (r_step == STEP_HI) r_ph <= mul_p;
                if (r_step == STEP_MID) r_pm <= mul_p;
                if (r_step == LAST_STEP) begin
                    r_run  <= 1'b0;
                    o_done <= 1'b1;
                    o_p    <= (FBITS == 64) ? {r_pm ^ r_pl, r_pl ^ mul_p} : {32'd0, mul_p};
                end
                r_step <= r_step + 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- src/nimber_field_arithmetic_unit.sv -----
// Nimber field arithmetic unit: sequencer around one shared nim multiplier.
// Add, zero divides and unused codes finish without the multiplier; multiply takes one
// product; power, inverse and divide square and multiply over an exponent. One item at
// a time: busy stays high after accept and through the one-cycle result strobe, which
// cannot be stalled; synchronous active-low reset idles it.
`timescale 1ns / 1ps
`default_nettype none
module nimber_field_arithmetic_unit
    import nfau_pkg::*;
#(
    parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_in  i_in,
    output logic      busy,
    output logic      o_valid,
    output t_out      o_out
);
    localparam int FW = (FIELD_WIDTH > 64) ? 64 : ((FIELD_WIDTH < 8) ? 8 : FIELD_WIDTH);
    localparam int FBITS = (FW >= 64) ? 64 : (FW >= 32) ? 32 : (FW >= 16) ? 16 : 8;
    localparam logic [63:0] MASK = (FBITS == 64) ? '1 : ((64'd1 << FBITS) - 64'd1);

    t_state      r_state, n_state;
    logic [2:0]  r_func;
    logic [63:0] r_a, r_bn, r_exp, r_acc, r_sq;
    logic        r_err;
    logic [63:0] in_a, in_b;
    logic        in_err, in_short;
    logic        mul_start, mul_done;
    logic [63:0] mul_x, mul_y, mul_p;

    nfau_mul #(.FBITS(FBITS)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_x(mul_x), .i_y(mul_y), .o_done(mul_done), .o_p(mul_p)
    );

    assign in_a   = i_in.operand_a & MASK;
    assign in_b   = i_in.operand_b & MASK;
    assign in_err = (i_in.func == FUNC_DIV && in_b == 64'd0) ||
                    (i_in.func == FUNC_INV && in_a == 64'd0);
    // Add, unused codes and zero divides finish without the multiplier.
    assign in_short = in_err || i_in.func == FUNC_ADD || i_in.func > FUNC_INV;

    assign o_out.result      = r_acc;
    assign o_out.zero_divide = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        mul_x     = r_acc;
        mul_y     = r_sq;
        busy      = 1'b1;
        o_valid   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) n_state = in_short ? ST_DONE : ST_CHECK;
            end
            ST_CHECK: begin
                if (r_exp != 64'd0) begin
                    mul_start = 1'b1;
                    if (r_exp[0]) n_state = ST_MUL_WAIT;
                    else begin
                        mul_x   = r_sq;
                        n_state = ST_SQ_WAIT;
                    end
                end else if (r_func inside {FUNC_MUL, FUNC_DIV}) begin
                    // Finish with a times b, or a times the inverse of b.
                    mul_start = 1'b1;
                    mul_x     = r_a;
                    mul_y     = (r_func == FUNC_DIV) ? r_acc : r_bn;
                    n_state   = ST_FIN_WAIT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_x     = r_sq;
                    n_state   = ST_SQ_WAIT;
                end
            end
            ST_SQ_WAIT:  if (mul_done) n_state = ST_CHECK;
            ST_FIN_WAIT: if (mul_done) n_state = ST_DONE;
            ST_DONE: begin
                o_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Square-and-multiply walks the exponent from its low bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func <= FUNC_ADD;
            r_a    <= 64'd0;
            r_bn   <= 64'd0;
            r_exp  <= 64'd0;
            r_acc  <= 64'd0;
            r_sq   <= 64'd0;
            r_err  <= 1'b0;
        end else if (r_state == ST_IDLE && start) begin
            r_func <= i_in.func;
            r_a    <= in_a;
            r_bn   <= in_b;
            r_err  <= in_err;
            if (in_short) r_acc <= (i_in.func == FUNC_ADD) ? (in_a ^ in_b) : 64'd0;
            else          r_acc <= 64'd1;
            case (i_in.func)
                FUNC_POW: begin
                    r_sq  <= in_a;
                    r_exp <= i_in.operand_b;
                end
                FUNC_INV: begin
                    r_sq  <= in_a;
                    r_exp <= MASK - 64'd1;
                end
                FUNC_DIV: begin
                    r_sq  <= in_b;
                    r_exp <= MASK - 64'd1;
                end
                default: begin
                    r_sq  <= in_a;
                    r_exp <= 64'd0;
                end
            endcase
        end else if (mul_done) begin
            case (r_state)
                ST_MUL_WAIT, ST_FIN_WAIT: r_acc <= mul_p;
                ST_SQ_WAIT: begin
                    r_sq  <= mul_p;
                    r_exp <= r_exp >> 1;
                end
                default: r_acc <= r_acc;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- verif/nimber_field_arithmetic_unit_checker.sv -----
// Checker for the nimber unit: predicts each transfer's result and compares it.
`timescale 1ns / 1ps
module nimber_field_arithmetic_unit_checker
    import nfau_pkg::*;
#(
    parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_in  i_in,
    input  wire logic busy,
    input  wire logic o_valid,
    input  wire t_out o_out,
    output int        o_errors,
    output int        o_pending
);
    t_out expected_results[$];
    int   err_count;

    function automatic int field_bits();
        int w;
        int p;
        w = FIELD_WIDTH;
        p = 8;
        if (w > 64) w = 64;
        if (w < 8) w = 8;
        while (p * 2 <= w) p = p * 2;
        return p;
    endfunction

    function automatic logic [63:0] field_mask();
        if (field_bits() >= 64) return '1;
        return (64'd1 << field_bits()) - 64'd1;
    endfunction

    // Split into halves; fold the high product by the top half-bit.
    function automatic logic [1:0] nim_mul2(logic [1:0] x, logic [1:0] y);
        logic lo;
        logic hi;
        logic mid;
        if (x <= 2'd1 || y <= 2'd1) return x * y;
        lo  = x[0] & y[0];
        hi  = x[1] & y[1];
        mid = ((x[0] ^ x[1]) & (y[0] ^ y[1])) ^ lo ^ hi;
        return {mid ^ hi, lo ^ hi};
    endfunction

    function automatic logic [3:0] nim_mul4(logic [3:0] x, logic [3:0] y);
        logic [1:0] lo;
        logic [1:0] hi;
        logic [1:0] mid;
        if (x <= 4'd1 || y <= 4'd1) return x * y;
        lo  = nim_mul2(x[1:0], y[1:0]);
        hi  = nim_mul2(x[3:2], y[3:2]);
        mid = nim_mul2(x[1:0] ^ x[3:2], y[1:0] ^ y[3:2]) ^ lo ^ hi;
        return {mid ^ hi, lo ^ nim_mul2(hi, 2'h2)};
    endfunction

    function automatic logic [7:0] nim_mul8(logic [7:0] x, logic [7:0] y);
        logic [3:0] lo;
        logic [3:0] hi;
        logic [3:0] mid;
        if (x <= 8'd1 || y <= 8'd1) return x * y;
        lo  = nim_mul4(x[3:0], y[3:0]);
        hi  = nim_mul4(x[7:4], y[7:4]);
        mid = nim_mul4(x[3:0] ^ x[7:4], y[3:0] ^ y[7:4]) ^ lo ^ hi;
        return {mid ^ hi, lo ^ nim_mul4(hi, 4'h8)};
    endfunction

    function automatic logic [15:0] nim_mul16(logic [15:0] x, logic [15:0] y);
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] mid;
        if (x <= 16'd1 || y <= 16'd1) return x * y;
        lo  = nim_mul8(x[7:0], y[7:0]);
        hi  = nim_mul8(x[15:8], y[15:8]);
        mid = nim_mul8(x[7:0] ^ x[15:8], y[7:0] ^ y[15:8]) ^ lo ^ hi;
        return {mid ^ hi, lo ^ nim_mul8(hi, 8'h80)};
    endfunction

    function automatic logic [31:0] nim_mul32(logic [31:0] x, logic [31:0] y);
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] mid;
        if (x <= 32'd1 || y <= 32'd1) return x * y;
        lo  = nim_mul16(x[15:0], y[15:0]);
        hi  = nim_mul16(x[31:16], y[31:16]);
        mid = nim_mul16(x[15:0] ^ x[31:16], y[15:0] ^ y[31:16]) ^ lo ^ hi;
        return {mid ^ hi, lo ^ nim_mul16(hi, 16'h8000)};
    endfunction

    function automatic logic [63:0] nim_mul64(logic [63:0] x, logic [63:0] y);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] mid;
        if (x <= 64'd1 || y <= 64'd1) return x * y;
        lo  = nim_mul32(x[31:0], y[31:0]);
        hi  = nim_mul32(x[63:32], y[63:32]);
        mid = nim_mul32(x[31:0] ^ x[63:32], y[31:0] ^ y[63:32]) ^ lo ^ hi;
        return {mid ^ hi, lo ^ nim_mul32(hi, 32'h8000_0000)};
    endfunction

    // Smaller fields are subfields, so the 32-bit product serves them too.
    function automatic logic [63:0] field_mul(logic [63:0] x, logic [63:0] y);
        if (field_bits() >= 64) return nim_mul64(x, y);
        return {32'd0, nim_mul32(x[31:0], y[31:0])};
    endfunction

    function automatic logic [63:0] nim_pow(logic [63:0] base, logic [63:0] e);
        logic [63:0] acc;
        logic [63:0] sq;
        acc = 64'd1;
        sq  = base;
        while (e != 64'd0) begin
            if (e[0]) acc = field_mul(acc, sq);
            sq = field_mul(sq, sq);
            e  = e >> 1;
        end
        return acc;
    endfunction

    function automatic t_out predict_result(t_in item);
        t_out        r;
        logic [63:0] a;
        logic [63:0] b;
        a = item.operand_a & field_mask();
        b = item.operand_b & field_mask();
        r = '0;
        case (item.func)
            FUNC_ADD: r.result = a ^ b;
            FUNC_MUL: r.result = field_mul(a, b);
            FUNC_DIV: begin
                if (b == 64'd0) r.zero_divide = 1'b1;
                else r.result = field_mul(a, nim_pow(b, field_mask() - 64'd1));
            end
            FUNC_POW: r.result = nim_pow(a, item.operand_b);
            FUNC_INV: begin
                if (a == 64'd0) r.zero_divide = 1'b1;
                else r.result = nim_pow(a, field_mask() - 64'd1);
            end
            default: r = '0;
        endcase
        r.result = r.result & field_mask();
        return r;
    endfunction

    assign o_errors = err_count;

    always @(posedge i_clk) begin
        t_out want;
        int   bad;
        bad = 0;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with no transfer pending: result %h flag %b",
                         $time, o_out.result, o_out.zero_divide);
                bad++;
            end else begin
                want = expected_results.pop_front();
                if (want.result !== o_out.result) begin
                    $display("%0t: result mismatch: expected %h actual %h",
                             $time, want.result, o_out.result);
                    bad++;
                end
                if (want.zero_divide !== o_out.zero_divide) begin
                    $display("%0t: zero_divide mismatch: expected %b actual %b",
                             $time, want.zero_divide, o_out.zero_divide);
                    bad++;
                end
            end
        end
        if (i_rst_n && start && !busy) expected_results.push_back(predict_result(i_in));
        if (bad != 0) err_count <= err_count + bad;
        o_pending <= expected_results.size();
    end
endmodule

// ----- verif/nimber_field_arithmetic_unit_tb.sv -----
// Testbench top for the nimber unit: stimulus, idling and the final verdict.
`timescale 1ns / 1ps
module nimber_field_arithmetic_unit_tb;
    import nfau_pkg::*;

    localparam int RANDOM_ITEMS = 1080;
    localparam longint CYCLE_LIMIT = 40_000_000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_in  i_in;
    logic busy;
    logic o_valid;
    t_out o_out;
    int   errors;
    int   pending;
    longint cycles;

    nimber_field_arithmetic_unit i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_in   (i_in),
        .busy   (busy),
        .o_valid(o_valid),
        .o_out  (o_out)
    );

    nimber_field_arithmetic_unit_checker i_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_in     (i_in),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_out    (o_out),
        .o_errors (errors),
        .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return 64'd1;
            2: return '1;
            3: return 64'($urandom_range(2, 255));
            4: return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Keep slow operations rare: power, inverse and divide run a chain of multiplier products.
    function automatic t_in rand_item();
        t_in item;
        int  pick;
        pick = $urandom_range(0, 99);
        item.operand_a = rand_operand();
        item.operand_b = rand_operand();
        if (pick < 40) item.func = FUNC_ADD;
        else if (pick < 86) item.func = FUNC_MUL;
        else if (pick < 89) item.func = FUNC_DIV;
        else if (pick < 94) begin
            item.func = FUNC_POW;
            if ($urandom_range(0, 1) == 1) item.operand_b = 64'($urandom_range(0, 63));
        end else if (pick < 97) item.func = FUNC_INV;
        else item.func = 3'($urandom_range(int'(FUNC_INV) + 1, 7));
        return item;
    endfunction

    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 2) == 0) return;
        if ($urandom_range(0, 9) == 0) n = $urandom_range(20, 150);
        else n = $urandom_range(1, 3);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Hold the item until the block takes it at an edge with busy low.
    task automatic send_item(t_in item);
        start <= 1'b1;
        i_in  <= item;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic t_in make_item(logic [2:0] f, logic [63:0] a, logic [63:0] b);
        t_in item;
        item.func      = f;
        item.operand_a = a;
        item.operand_b = b;
        return item;
    endfunction

    initial begin
        t_in directed[$];
        start   = 1'b0;
        i_in    = '0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back(make_item(FUNC_ADD, '1, 64'h5555_5555_5555_5555));
        directed.push_back(make_item(FUNC_ADD, 64'd0, 64'd0));
        directed.push_back(make_item(FUNC_MUL, '1, '1));
        directed.push_back(make_item(FUNC_MUL, 64'd0, '1));
        directed.push_back(make_item(FUNC_MUL, 64'd1 << 63, 64'd1 << 63));
        directed.push_back(make_item(FUNC_MUL, 64'd2, 64'd3));
        directed.push_back(make_item(FUNC_MUL, 64'd1 << 32, 64'd1 << 32));
        directed.push_back(make_item(FUNC_DIV, 64'h1234_5678_9abc_def0, 64'd0));
        directed.push_back(make_item(FUNC_DIV, '1, '1));
        directed.push_back(make_item(FUNC_DIV, 64'd7, 64'd1 << 63));
        directed.push_back(make_item(FUNC_POW, 64'd0, 64'd0));
        directed.push_back(make_item(FUNC_POW, '1, 64'd0));
        directed.push_back(make_item(FUNC_POW, 64'd2, '1));
        directed.push_back(make_item(FUNC_POW, 64'd0, 64'd5));
        directed.push_back(make_item(FUNC_POW, 64'h0f0f_0f0f_0f0f_0f0f, ~64'd1));
        directed.push_back(make_item(FUNC_INV, 64'd0, '1));
        directed.push_back(make_item(FUNC_INV, 64'd1, 64'd0));
        directed.push_back(make_item(FUNC_INV, '1, 64'd0));
        directed.push_back(make_item(FUNC_INV, 64'd1 << 63, 64'd0));
        directed.push_back(make_item(3'(FUNC_INV) + 3'd1, '1, '1));
        directed.push_back(make_item(3'(FUNC_INV) + 3'd2, 64'd5, 64'd0));
        directed.push_back(make_item(3'(FUNC_INV) + 3'd3, '1, '1));

        foreach (directed[i]) begin
            send_item(directed[i]);
            idle_gap();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_item(rand_item());
            if (n == RANDOM_ITEMS / 2) begin
                start <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end else if (n % 200 >= 150) begin
                // back-to-back stretch
            end else begin
                idle_gap();
            end
        end
        start <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
